// File: rtl/pes_pkg.sv
`timescale 1ns / 1ps
package pes_pkg;
   localparam int EVENT_SLOTS = 16;
   localparam int OWNER_BITS = 8;
   localparam int SLOT_BITS = $clog2(EVENT_SLOTS);
   localparam int CNT_BITS = $clog2(EVENT_SLOTS + 1);
   localparam logic [62:0] TMAX = 63'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [6:0] POP_LIMIT_MAX = 7'd64;

   localparam logic [1:0] REQ_REGISTER = 2'd0;
   localparam logic [1:0] REQ_UNREGISTER = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [2:0] ST_POPPED = 3'd0;
   localparam logic [2:0] ST_NONE_DUE = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;

   localparam logic CSR_START_TIME = 1'b0;
   localparam logic CSR_MAX_POPS = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        event_kind;
      logic [7:0]  owner_id;
      logic [39:0] period_ns;
      logic [62:0] now_time;
      logic [31:0] delta_ns;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        out_kind;
      logic [7:0]  out_owner;
      logic [62:0] out_due_time;
      logic        pop_capped;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic                 load_req;   // latch request, compute due time
      logic                 frame_adv;  // frame += delta
      logic                 frame_load; // frame = start_time
      logic                 do_insert;  // insert pending event
      logic                 do_remove;  // remove slot at match position
      logic                 do_pop;     // take head into pending, remove it
   } pes_cmd_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] count;
      logic                head_due;   // head valid and below frame time
      logic                match_found;
      logic [1:0]          req_type;
   } pes_stat_type;

   function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? TMAX : s[62:0];
   endfunction
endpackage

// File: rtl/pes_datapath.sv
`timescale 1ns / 1ps
module pes_datapath import pes_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  logic [62:0]  start_time,
   input  pes_cmd_type  cmd,
   output pes_stat_type stat,
   output logic [62:0]  pend_time,
   output logic         pend_kind,
   output logic [7:0]   pend_owner
);
   logic [EVENT_SLOTS-1:0] valid_ff, valid_in;
   logic [62:0] time_ff [EVENT_SLOTS];
   logic [39:0] period_ff [EVENT_SLOTS];
   logic        kind_ff [EVENT_SLOTS];
   logic [7:0]  owner_ff [EVENT_SLOTS];
   logic [62:0] frame_ff;
   logic [1:0]  rtype_ff;
   logic [7:0]  rowner_ff;
   logic [39:0] pper_ff;
   logic [62:0] ptime_ff;   // time the pending event is inserted at
   logic [62:0] pdue_ff;    // due time of the popped event
   logic        pkind_ff;
   logic [7:0]  powner_ff;
   logic [EVENT_SLOTS-1:0] gt_vec, gt_prev, valid_prev, match_vec, ins_here;
   logic [EVENT_SLOTS-2:0] after_match, take_next;
   logic [CNT_BITS-1:0] count;
   logic [39:0] per_fix;
   logic [7:0]  own_mask;
   logic [62:0] next_due;

   assign per_fix = (req_word.period_ns == '0) ? 40'd1 : req_word.period_ns;
   assign own_mask = 8'((1 << OWNER_BITS) - 1);
   assign next_due = sat_add(time_ff[0], {23'd0, period_ff[0]});

   always_comb begin
      count = '0;
      for (int i = 0; i < EVENT_SLOTS; i++) count = count + CNT_BITS'(valid_ff[i]);
      for (int i = 0; i < EVENT_SLOTS; i++) begin
         gt_vec[i] = valid_ff[i] && (time_ff[i] > ptime_ff);
         match_vec[i] = valid_ff[i] && kind_ff[i] && (owner_ff[i] == rowner_ff);
      end
      gt_prev = {gt_vec[EVENT_SLOTS-2:0], 1'b0};
      valid_prev = {valid_ff[EVENT_SLOTS-2:0], 1'b1};
      // insert slot: first entry later than pending, or first free slot
      for (int i = 0; i < EVENT_SLOTS; i++)
         ins_here[i] = !gt_prev[i] && (gt_vec[i] || (!valid_ff[i] && valid_prev[i]));
      after_match[0] = match_vec[0];
      for (int i = 1; i < EVENT_SLOTS - 1; i++)
         after_match[i] = after_match[i-1] | match_vec[i];
      for (int i = 0; i < EVENT_SLOTS - 1; i++)
         take_next[i] = cmd.do_pop || (cmd.do_remove && after_match[i]);
   end

   assign stat.count = count;
   assign stat.head_due = valid_ff[0] && (time_ff[0] < frame_ff);
   assign stat.match_found = |match_vec;
   assign stat.req_type = rtype_ff;
   assign pend_time = pdue_ff;
   assign pend_kind = pkind_ff;
   assign pend_owner = powner_ff;

   // valid entries are a prefix; shift up to insert, down to remove or pop
   always_comb begin
      valid_in = valid_ff;
      if (cmd.do_insert) valid_in = {valid_ff[EVENT_SLOTS-2:0], 1'b1};
      else if (cmd.do_remove || cmd.do_pop) valid_in = {1'b0, valid_ff[EVENT_SLOTS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         frame_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.frame_load) frame_ff <= start_time;
         else if (cmd.frame_adv) frame_ff <= sat_add(frame_ff, {31'd0, req_word.delta_ns});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rtype_ff <= req_word.req_type;
         rowner_ff <= req_word.owner_id & own_mask;
         pper_ff <= per_fix;
         ptime_ff <= sat_add(req_word.now_time, {23'd0, per_fix});
         pkind_ff <= req_word.event_kind;
         powner_ff <= req_word.event_kind ? (req_word.owner_id & own_mask) : 8'd0;
      end else if (cmd.do_pop) begin
         pper_ff <= period_ff[0];
         ptime_ff <= next_due;
         pdue_ff <= time_ff[0];
         pkind_ff <= kind_ff[0];
         powner_ff <= owner_ff[0];
      end
   end

   // table: later entries move up one on insert, down one on remove/pop
   always_ff @(posedge clock) begin
      if (cmd.do_insert) begin
         if (ins_here[0]) begin
            time_ff[0] <= ptime_ff;
            period_ff[0] <= pper_ff;
            kind_ff[0] <= pkind_ff;
            owner_ff[0] <= powner_ff;
         end
         for (int i = 1; i < EVENT_SLOTS; i++) begin
            if (gt_prev[i]) begin
               time_ff[i] <= time_ff[i-1];
               period_ff[i] <= period_ff[i-1];
               kind_ff[i] <= kind_ff[i-1];
               owner_ff[i] <= owner_ff[i-1];
            end else if (ins_here[i]) begin
               time_ff[i] <= ptime_ff;
               period_ff[i] <= pper_ff;
               kind_ff[i] <= pkind_ff;
               owner_ff[i] <= powner_ff;
            end
         end
      end else begin
         for (int i = 0; i < EVENT_SLOTS - 1; i++) begin
            if (take_next[i]) begin
               time_ff[i] <= time_ff[i+1];
               period_ff[i] <= period_ff[i+1];
               kind_ff[i] <= kind_ff[i+1];
               owner_ff[i] <= owner_ff[i+1];
            end
         end
      end
   end
endmodule

// File: rtl/pes_control.sv
`timescale 1ns / 1ps
module pes_control import pes_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         cfg_frame_load,
   input  logic [6:0]   max_pops,
   input  pes_stat_type stat,
   input  logic [62:0]  pend_time,
   input  logic         pend_kind,
   input  logic [7:0]   pend_owner,
   output pes_cmd_type  cmd,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_EXEC = 5'b00010, S_POP = 5'b00100,
      S_REINS = 5'b01000, S_OUT = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0] npop_ff, npop_in, limit;
   logic rv_ff, rv_in;
   rsp_word_type rw_ff, rw_in;
   logic acc;

   assign limit = (max_pops == 7'd0) ? 7'd1
                : (max_pops > POP_LIMIT_MAX) ? POP_LIMIT_MAX : max_pops;
   assign acc = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_word = rw_ff;

   always_comb begin
      state_in = state_ff;
      npop_in = npop_ff;
      rv_in = rv_ff && rsp_stall;
      rw_in = rw_ff;
      cmd = '0;
      cmd.frame_load = cfg_frame_load;
      case (state_ff)
         S_IDLE: begin
            if (acc && (req_word.req_type inside {REQ_REGISTER, REQ_UNREGISTER, REQ_TICK})) begin
               cmd.load_req = 1'b1;
               cmd.frame_adv = (req_word.req_type == REQ_TICK);
               npop_in = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rw_in = '0;
            rw_in.last = 1'b1;
            case (stat.req_type)
               REQ_REGISTER: begin
                  if (stat.count == CNT_BITS'(EVENT_SLOTS)) rw_in.status = ST_FULL;
                  else begin
                     rw_in.status = ST_DONE;
                     cmd.do_insert = 1'b1;
                  end
                  rv_in = 1'b1;
                  state_in = S_IDLE;
               end
               REQ_UNREGISTER: begin
                  rw_in.status = stat.match_found ? ST_DONE : ST_NOT_FOUND;
                  cmd.do_remove = stat.match_found;
                  rv_in = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  if (stat.count == '0) begin
                     rw_in.status = ST_EMPTY;
                     rv_in = 1'b1;
                     state_in = S_IDLE;
                  end else if (!stat.head_due) begin
                     rw_in.status = ST_NONE_DUE;
                     rv_in = 1'b1;
                     state_in = S_IDLE;
                  end else state_in = S_POP;
               end
            endcase
         end
         S_POP: begin
            cmd.do_pop = 1'b1;
            npop_in = npop_ff + 7'd1;
            state_in = S_REINS;
         end
         S_REINS: begin
            // pending holds popped event; put it back one period on
            cmd.do_insert = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            // table is settled here, so last and capped are known up front
            if (!rv_ff || !rsp_stall) begin
               rw_in = '0;
               rw_in.status = ST_POPPED;
               rw_in.out_kind = pend_kind;
               rw_in.out_owner = pend_owner;
               rw_in.out_due_time = pend_time;
               rv_in = 1'b1;
               if (!stat.head_due || npop_ff >= limit) begin
                  rw_in.last = 1'b1;
                  rw_in.pop_capped = stat.head_due;
                  state_in = S_IDLE;
               end else state_in = S_POP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         npop_ff <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         npop_ff <= npop_in;
      end
   end
   always_ff @(posedge clock) rw_ff <= rw_in;
endmodule

// File: rtl/periodic_event_scheduler.sv
`timescale 1ns / 1ps
// Periodic event scheduler: a time-sorted table of EVENT_SLOTS periodic events.
// Request words come in on req_valid/req_stall; the block stalls them from the
// accept until the final response word of that request has been taken, so
// one request is worked at a time.
// Register, unregister and a tick with an empty table or nothing due give one
// response word, registered out of the EXEC state, which the accept enters.
// A tick advances the frame time, then pops each due head event, reinserting
// it one period later. Each pop runs the POP, REINS and OUT states in turn (pop,
// sorted reinsert, emit), and each word is registered out of OUT.
// At most max_pops_per_tick pops per tick (0 counts as 1, over 64 as 64); the
// final word carries last and, when it stopped at the limit with an event still due,
// pop_capped. A stalled response word holds unchanged; the next word waits on it.
// Reset empties the table, sets frame time to 0 and the pop limit to 64.
// CSR: 64-bit data at byte 0 (start_time, also loads frame time) and 8
// (max_pops_per_tick). Write only while no request is in flight.
module periodic_event_scheduler import pes_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [63:0]  pwdata,
   output logic [63:0]  prdata,
   output logic         pready
);
   logic [62:0] start_ff;
   logic [6:0]  maxp_ff;
   logic        wr, ridx;
   pes_cmd_type cmd;
   pes_stat_type stat;
   logic [62:0] pend_time;
   logic        pend_kind;
   logic [7:0]  pend_owner;

   assign pready = 1'b1;
   assign ridx = paddr[3];
   assign wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         maxp_ff <= POP_LIMIT_MAX;
      end else if (wr && ridx == CSR_START_TIME) start_ff <= pwdata[62:0];
      else if (wr && ridx == CSR_MAX_POPS) maxp_ff <= pwdata[6:0];
   end
   assign prdata = (ridx == CSR_START_TIME) ? {1'b0, start_ff} : {57'd0, maxp_ff};

   pes_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .cfg_frame_load(wr && ridx == CSR_START_TIME), .max_pops(maxp_ff),
      .stat, .pend_time, .pend_kind, .pend_owner, .cmd,
      .rsp_valid, .rsp_stall, .rsp_word
   );

   pes_datapath u_dp (
      .clock, .reset, .req_word, .start_time(pwdata[62:0]), .cmd, .stat,
      .pend_time, .pend_kind, .pend_owner
   );

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while response held");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_BITS'(EVENT_SLOTS)) else $error("count overflow");
   a_no_ins_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.do_insert && stat.req_type == REQ_REGISTER) |-> stat.count < CNT_BITS'(EVENT_SLOTS))
      else $error("insert into full table");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled response word changed");
endmodule

// File: test/periodic_event_scheduler_test.sv
`timescale 1ns / 1ps
module periodic_event_scheduler_test import pes_pkg::*; ();

   localparam int IDLE_LIMIT = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [63:0]  pwdata = '0;
   logic [63:0]  prdata;
   logic         pready;

   periodic_event_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the event table, kept in due time order.
   logic [62:0] sh_time [EVENT_SLOTS];
   logic [39:0] sh_period [EVENT_SLOTS];
   logic        sh_kind [EVENT_SLOTS];
   logic [7:0]  sh_owner [EVENT_SLOTS];
   int          sh_count;
   logic [62:0] sh_frame;
   logic [6:0]  sh_pop_limit;

   rsp_word_type expected_words[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  quiet = 1'b0;   // no idling in the closing stretch

   function automatic logic [62:0] add_sat(logic [62:0] a, logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? 63'h7FFF_FFFF_FFFF_FFFF : s[62:0];
   endfunction

   function automatic void expect_word(rsp_word_type w);
      expected_words.insert(expected_words.size(), w);
   endfunction

   // Sorted insert after equal due times; returns 0 on a full table.
   function automatic bit table_insert(logic [62:0] t, logic [39:0] p, logic k,
                                       logic [7:0] o);
      int pos;
      pos = 0;
      if (sh_count >= EVENT_SLOTS) return 1'b0;
      while (pos < sh_count && sh_time[pos] <= t) pos++;
      for (int i = sh_count; i > pos; i--) begin
         sh_time[i] = sh_time[i-1];
         sh_period[i] = sh_period[i-1];
         sh_kind[i] = sh_kind[i-1];
         sh_owner[i] = sh_owner[i-1];
      end
      sh_time[pos] = t;
      sh_period[pos] = p;
      sh_kind[pos] = k;
      sh_owner[pos] = o;
      sh_count++;
      return 1'b1;
   endfunction

   function automatic void table_remove(int pos);
      for (int i = pos; i + 1 < sh_count; i++) begin
         sh_time[i] = sh_time[i+1];
         sh_period[i] = sh_period[i+1];
         sh_kind[i] = sh_kind[i+1];
         sh_owner[i] = sh_owner[i+1];
      end
      sh_count--;
   endfunction

   function automatic rsp_word_type status_word(logic [2:0] st);
      rsp_word_type w;
      w = '0;
      w.status = st;
      w.last = 1'b1;
      return w;
   endfunction

   // Works out the words one request causes and queues them.
   function automatic void predict_schedule(req_word_type r);
      logic [39:0] per;
      logic [62:0] t;
      logic [39:0] p;
      logic        kd;
      logic [7:0]  ow;
      int          limit;
      int          k;
      bit          found;
      rsp_word_type w;
      per = (r.period_ns == '0) ? 40'd1 : r.period_ns;
      case (r.req_type)
         REQ_REGISTER: begin
            found = table_insert(add_sat(r.now_time, {23'd0, per}), per, r.event_kind,
                                 r.event_kind ? r.owner_id : 8'd0);
            expect_word(status_word(found ? ST_DONE : ST_FULL));
         end
         REQ_UNREGISTER: begin
            found = 1'b0;
            for (int i = 0; i < sh_count && !found; i++)
               if (sh_kind[i] && sh_owner[i] == r.owner_id) begin
                  table_remove(i);
                  found = 1'b1;
               end
            expect_word(status_word(found ? ST_DONE : ST_NOT_FOUND));
         end
         REQ_TICK: begin
            sh_frame = add_sat(sh_frame, {31'd0, r.delta_ns});
            limit = (sh_pop_limit == 0) ? 1 : (sh_pop_limit > 64 ? 64 : sh_pop_limit);
            if (sh_count == 0) begin
               expect_word(status_word(ST_EMPTY));
            end else begin
               k = 0;
               while (k < limit && sh_count > 0 && sh_time[0] < sh_frame) begin
                  t = sh_time[0]; p = sh_period[0]; kd = sh_kind[0]; ow = sh_owner[0];
                  table_remove(0);
                  void'(table_insert(add_sat(t, {23'd0, p}), p, kd, ow));
                  w = '0;
                  w.status = ST_POPPED;
                  w.out_kind = kd;
                  w.out_owner = ow;
                  w.out_due_time = t;
                  expect_word(w);
                  k++;
               end
               if (k == 0) begin
                  expect_word(status_word(ST_NONE_DUE));
               end else begin
                  w = expected_words.pop_back();
                  w.last = 1'b1;
                  w.pop_capped = (k >= limit && sh_count > 0 && sh_time[0] < sh_frame);
                  expect_word(w);
               end
            end
         end
         default: ;  // unknown type: dropped, nothing comes back
      endcase
   endfunction

   // Result checker and receiver-side stall bursts.
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_word);
            error_count++;
         end else begin
            exp_w = expected_words.pop_front();
            if (rsp_word.status !== exp_w.status)
               $display("%0t: status exp %0d got %0d", $time, exp_w.status, rsp_word.status);
            if (rsp_word.out_kind !== exp_w.out_kind)
               $display("%0t: kind exp %0d got %0d", $time, exp_w.out_kind,
                        rsp_word.out_kind);
            if (rsp_word.out_owner !== exp_w.out_owner)
               $display("%0t: owner exp %0d got %0d", $time, exp_w.out_owner,
                        rsp_word.out_owner);
            if (rsp_word.out_due_time !== exp_w.out_due_time)
               $display("%0t: due exp %0d got %0d", $time, exp_w.out_due_time,
                        rsp_word.out_due_time);
            if (rsp_word.pop_capped !== exp_w.pop_capped)
               $display("%0t: capped exp %0d got %0d", $time, exp_w.pop_capped,
                        rsp_word.pop_capped);
            if (rsp_word.last !== exp_w.last)
               $display("%0t: last exp %0d got %0d", $time, exp_w.last, rsp_word.last);
            if (rsp_word !== exp_w) error_count++;
         end
      end
   end

   int stall_left = 0;
   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(7) == 0) begin
         stall_left <= $urandom_range(4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: cycles with no word moving on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("periodic_event_scheduler_test: FAIL");
         $finish;
      end
   end

   // Sends one word, with an optional random gap ahead of it; valid stays up
   // after the accept until the next word or an idle phase replaces it.
   task automatic send_request(req_word_type r);
      int gap;
      if (!quiet && $urandom_range(5) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_schedule(r);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Register write while idle; two-phase bus access.
   task automatic write_csr(logic idx, logic [63:0] value);
      drain_results();
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= idx ? 4'd8 : 4'd0; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == CSR_START_TIME) begin
         sh_frame = value[62:0];
      end else begin
         sh_pop_limit = value[6:0];
      end
      @(posedge clock);
   endtask

   function automatic req_word_type make_req(logic [1:0] ty, logic k, logic [7:0] o,
                                             logic [39:0] p, logic [62:0] n,
                                             logic [31:0] d);
      req_word_type r;
      r.req_type = ty; r.event_kind = k; r.owner_id = o;
      r.period_ns = p; r.now_time = n; r.delta_ns = d;
      return r;
   endfunction

   task automatic test_directed();
      send_request(make_req(REQ_TICK, 1'b0, 8'd0, 40'd0, 63'd0, 32'hFFFF_FFFF)); // empty
      send_request(make_req(REQ_REGISTER, 1'b1, 8'hFF, 40'd0, 63'd0, 32'd0));   // zero period
      send_request(make_req(REQ_REGISTER, 1'b0, 8'hA5, 40'hFF_FFFF_FFFF, 63'd0,
                            32'd0));                                           // physics
      send_request(make_req(REQ_REGISTER, 1'b1, 8'h00, 40'd5, TMAX, 32'd0));    // saturation
      send_request(make_req(REQ_UNREGISTER, 1'b0, 8'hA5, 40'd0, 63'd0, 32'd0)); // physics kept
      send_request(make_req(REQ_TICK, 1'b0, 8'd0, 40'd0, 63'd0, 32'd0));        // due, capped
      send_request(make_req(REQ_TICK, 1'b1, 8'hFF, 40'hFF_FFFF_FFFF, TMAX, 32'd10));
      send_request(make_req(REQ_RESERVED, 1'b1, 8'hFF, 40'hFF_FFFF_FFFF, TMAX,
                            32'hFFFF_FFFF));
      send_request(make_req(REQ_UNREGISTER, 1'b1, 8'hFF, 40'd0, 63'd0, 32'd0));
      send_request(make_req(REQ_UNREGISTER, 1'b1, 8'hFF, 40'd0, 63'd0, 32'd0)); // not found
      for (int i = 0; i < 16; i++)                                        // fill, then full
         send_request(make_req(REQ_REGISTER, i[0], i[7:0], 40'd3 + 40'(i), 63'd0, 32'd0));
      write_csr(CSR_MAX_POPS, 64'd1);
      send_request(make_req(REQ_TICK, 1'b0, 8'd0, 40'd0, 63'd0, 32'd100));      // capped
      write_csr(CSR_MAX_POPS, 64'd0);
      send_request(make_req(REQ_TICK, 1'b0, 8'd0, 40'd0, 63'd0, 32'd1));
   endtask

   // Saturated frame time with an out-of-range pop limit.
   task automatic test_limits();
      write_csr(CSR_MAX_POPS, 64'd127);
      write_csr(CSR_START_TIME, {1'b0, TMAX});
      send_request(make_req(REQ_TICK, 1'b0, 8'd0, 40'd0, 63'd0, 32'hFFFF_FFFF));
      write_csr(CSR_MAX_POPS, 64'd64);
      write_csr(CSR_START_TIME, 64'd0);
   endtask

   task automatic test_random(int count);
      req_word_type r;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         r.event_kind = 1'($urandom_range(1));
         r.owner_id = $urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(3));
         r.period_ns = $urandom_range(9) == 0 ? {8'($urandom), 32'($urandom)}
                                              : 40'($urandom_range(40));
         r.now_time = $urandom_range(19) == 0 ? {31'($urandom), 32'($urandom)}
                                              : 63'($urandom_range(200));
         r.delta_ns = $urandom_range(9) == 0 ? 32'($urandom) : 32'($urandom_range(30));
         if (sel < 40) r.req_type = REQ_REGISTER;
         else if (sel < 55) r.req_type = REQ_UNREGISTER;
         else if (sel < 97) r.req_type = REQ_TICK;
         else r.req_type = REQ_RESERVED;
         send_request(r);
         if (i == count / 2) drain_results();   // sender holds until all caught up
      end
   endtask

   initial begin
      sh_count = 0;
      sh_frame = '0;
      sh_pop_limit = 7'd64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      write_csr(CSR_MAX_POPS, 64'd3);
      test_random(120);
      write_csr(CSR_MAX_POPS, 64'd64);
      write_csr(CSR_START_TIME, 64'd1000);
      test_random(160);
      quiet = 1'b1;
      test_random(70);
      drain_results();
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("periodic_event_scheduler_test: PASS");
      end else begin
         $display("periodic_event_scheduler_test: FAIL");
      end
      $finish;
   end
endmodule
